/* hw/rtl/tdf_pkg.sv */
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants of the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

	// most factors delivered for one input beat
	localparam int MAX_RESULTS = 30;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// first even and first odd trial divisor
	localparam int TWO   = 2;
	localparam int THREE = 3;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_NONE  = 7'b0000010,
		ST_SHIFT = 7'b0000100,
		ST_DWAIT = 7'b0001000,
		ST_CHECK = 7'b0010000,
		ST_TAIL  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	// sequencer requests to the result stage
	typedef struct packed {
		logic push;   // new factor found, older pending one moves out
		logic flush;  // pending factor moves out as the final beat
		logic none;   // single beat with no factors
	} emit_req_t;

	// result stage status back to the sequencer
	typedef struct packed {
		logic push_ok;
		logic out_free;
	} emit_stat_t;

endpackage

/* hw/rtl/tdf_divider.sv */
// ----------------------------------------------------------------------------
// tdf_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_divider #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;

	// partial remainder with the next dividend bit shifted in, minus divisor
	assign trial = {rem_q, quot_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q  <= trial[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[W-2:0], quot_q[W-1]};
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == CW'(1));
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

/* hw/rtl/tdf_emit.sv */
// ----------------------------------------------------------------------------
// tdf_emit
// Result stage: holds the newest factor back until the next one or the end
// is known, so the final beat can carry tlast, and drives the output beat.
// ----------------------------------------------------------------------------
module tdf_emit
	import tdf_pkg::*;
#(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  emit_req_t    req,
	input  logic [W-1:0] factor_in,
	output emit_stat_t   stat,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_factor,
	output logic         out_last,
	output logic         out_none
);

	logic         pend_q;
	logic [W-1:0] pend_fac_q;
	logic         vld_q;
	logic [W-1:0] fac_q;
	logic         last_q;
	logic         none_q;
	logic         out_free;
	logic         load;

	assign out_free      = !vld_q || out_ready;
	assign stat.out_free = out_free;
	assign stat.push_ok  = !pend_q || out_free;

	// a push only reaches the output when something is already pending
	assign load = (req.push && pend_q) || req.flush || req.none;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (req.push) begin
				pend_q <= 1'b1;
			end else if (req.flush) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				vld_q <= 1'b1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push) begin
			pend_fac_q <= factor_in;
		end
		if (req.none) begin
			fac_q  <= '0;
			last_q <= 1'b1;
			none_q <= 1'b1;
		end else if (load) begin
			fac_q  <= pend_fac_q;
			last_q <= req.flush;
			none_q <= 1'b0;
		end
	end

	assign out_valid  = vld_q;
	assign out_factor = fac_q;
	assign out_last   = last_q;
	assign out_none   = none_q;

endmodule

/* hw/rtl/trial_division_factorizer_top.sv */
// ----------------------------------------------------------------------------
// trial_division_factorizer_top
// Prime factorization by trial division: factors of two first, then odd
// trial divisors through a bit-serial divider, remaining value last.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  s_*       in    tdata: value
//  m_*       out   tdata: factor, tlast: final factor, tuser: no_factors
//
//  factors of two are shifted out one at a time; each odd trial divisor is
//  one serial division followed by a check state
//  worst case a 31-bit prime: about 23170 odd trials a beat
//  one input beat is in work at a time; s_tready is high only when idle
//  a stalled m_tready holds the sequencer only when a factor must move out
//  asynchronous reset returns to idle with no pending results
// ----------------------------------------------------------------------------
module trial_division_factorizer_top
	import tdf_pkg::*;
#(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] m_tdata,   // [VALUE_WIDTH-1:0] factor
	output logic                                  m_tlast,
	output logic                                  m_tuser    // [0] no_factors
);

	localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int W      = VALUE_WIDTH;

	state_t           state_q, state_d;
	logic [W-1:0]     n_q, n_d;
	logic [W-1:0]     d_q, d_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             inner_q, inner_d;
	logic [W-1:0]     value;
	logic [W-1:0]     push_fac;
	logic             div_start;
	logic             div_done;
	logic [W-1:0]     div_quot;
	logic [W-1:0]     div_rem;
	emit_req_t        req;
	emit_stat_t       stat;
	logic [W-1:0]     out_factor;

	assign value    = s_tdata[W-1:0];
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		d_d       = d_q;
		cnt_d     = cnt_q;
		inner_d   = inner_q;
		req       = '0;
		push_fac  = d_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					n_d   = value;
					cnt_d = '0;
					if (value < W'(TWO)) begin
						state_d = ST_NONE;
					end else begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_NONE: begin
				if (stat.out_free) begin
					req.none = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (!n_q[0]) begin
					if (stat.push_ok) begin
						req.push = 1'b1;
						push_fac = W'(TWO);
						n_d      = n_q >> 1;
						cnt_d    = cnt_q + CNT_W'(1);
						if (cnt_q == CNT_W'(MAX_RESULTS - 1)) begin
							state_d = ST_FIN;
						end
					end
				end else begin
					d_d       = W'(THREE);
					inner_d   = 1'b0;
					div_start = 1'b1;
					state_d   = ST_DWAIT;
				end
			end
			ST_DWAIT: begin
				if (div_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// a fresh divisor ends the search once it exceeds n / d
				if (!inner_q && (d_q > div_quot)) begin
					state_d = ST_TAIL;
				end else if (div_rem == '0) begin
					if (stat.push_ok) begin
						req.push = 1'b1;
						n_d      = div_quot;
						cnt_d    = cnt_q + CNT_W'(1);
						inner_d  = 1'b1;
						if (cnt_q == CNT_W'(MAX_RESULTS - 1)) begin
							state_d = ST_FIN;
						end else begin
							div_start = 1'b1;
							state_d   = ST_DWAIT;
						end
					end
				end else begin
					d_d       = d_q + W'(TWO);
					inner_d   = 1'b0;
					div_start = 1'b1;
					state_d   = ST_DWAIT;
				end
			end
			ST_TAIL: begin
				if (n_q > W'(TWO)) begin
					if (stat.push_ok) begin
						req.push = 1'b1;
						push_fac = n_q;
						state_d  = ST_FIN;
					end
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					req.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			inner_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			inner_q <= inner_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		d_q <= d_d;
	end

	// divider loads the next value and divisor in the same edge they register
	tdf_divider #(
		.W (W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_d),
		.divisor  (d_d),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	tdf_emit #(
		.W (W)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.factor_in  (push_fac),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_factor (out_factor),
		.out_last   (m_tlast),
		.out_none   (m_tuser)
	);

	assign m_tdata = DATA_W'(out_factor);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("factor count beyond limit");

	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DWAIT) |-> (d_q[0] && (d_q >= W'(THREE))))
		else $error("trial divisor not odd or below three");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DWAIT))
		else $error("divider finished outside wait state");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		req.flush |=> (m_tvalid && m_tlast && !m_tuser))
		else $error("final factor beat not marked");

endmodule

/* verif/tb_trial_division_factorizer_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trial_division_factorizer_top
// Streams integers into the factorizer and checks every factor beat against
// a trial division predictor: a directed table of edge values first, then
// mostly cheap random values (small, smooth, or full-width with small factors)
// under random gaps on both sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_trial_division_factorizer_top;
	import tdf_pkg::*;

	localparam int VW         = 31;
	localparam int DATA_W     = ((VW + 7) / 8) * 8;
	localparam longint unsigned VALUE_MAX = (64'd1 << VW) - 1;
	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM   = 80;
	// random full-width values are kept only when they factor this quickly
	localparam int MAX_TRIALS = 600;
	localparam int HOLD_AT    = 40;
	localparam int HOLD_LEN   = 400;
	localparam int TAIL       = 4 * (VW + 1);
	// the limit covers the slowest run, the 31-bit prime, plus all the rest
	localparam longint LIMIT  = 10_000_000;

	typedef struct packed {
		logic [VW-1:0] factor;
		logic          last;
		logic          none;
	} factor_beat_t;

	typedef struct packed {
		logic [VW-1:0] value;
		logic          typed;   // expected beat given below, single final beat
		logic [VW-1:0] factor;
		logic          none;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;   // [VW-1:0] value
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;        // [VW-1:0] factor
	logic              m_tlast;
	logic              m_tuser;        // [0] no_factors

	factor_beat_t pending_factors[$];
	factor_beat_t next_factors[$];
	factor_beat_t want;
	longint       cycles = 0;
	int           errors = 0;
	int           rx_beats = 0;
	int           hold_left = 0;
	int           stall_left = 0;
	int           small_primes[16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
		47, 97};

	stim_row_t directed[N_DIRECTED] = '{
		'{31'd0,          1'b1, 31'd0,          1'b1},
		'{31'd1,          1'b1, 31'd0,          1'b1},
		'{31'd2,          1'b1, 31'd2,          1'b0},
		'{31'd3,          1'b1, 31'd3,          1'b0},
		'{31'd4,          1'b0, 31'd0,          1'b0},
		'{31'd6,          1'b0, 31'd0,          1'b0},
		'{31'd9,          1'b0, 31'd0,          1'b0},
		'{31'd12,         1'b0, 31'd0,          1'b0},
		'{31'd15,         1'b0, 31'd0,          1'b0},
		'{31'd25,         1'b0, 31'd0,          1'b0},
		'{31'd49,         1'b0, 31'd0,          1'b0},
		'{31'h4000_0000,  1'b0, 31'd0,          1'b0},  // thirty twos, most beats
		'{31'd1162261467, 1'b0, 31'd0,          1'b0},  // 3^19
		'{31'd223092870,  1'b0, 31'd0,          1'b0},  // primes 2 through 23
		'{31'd65521,      1'b0, 31'd0,          1'b0},
		'{31'd1000003,    1'b0, 31'd0,          1'b0},
		'{31'h5555_5555,  1'b0, 31'd0,          1'b0},
		'{31'h2AAA_AAAA,  1'b0, 31'd0,          1'b0},
		'{31'h7FFF_FFFE,  1'b0, 31'd0,          1'b0},
		'{31'h7FFF_FFFF,  1'b1, 31'h7FFF_FFFF,  1'b0}   // largest value is prime
	};

	trial_division_factorizer_top #(
		.VALUE_WIDTH(VW)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= LIMIT);
		$display("tb_trial_division_factorizer_top NOT OK");
		$finish;
	end

	// fills next_factors with the factor beats of v, returns odd trials made
	function automatic int factorize(input logic [VW-1:0] v);
		longint unsigned n;
		longint unsigned d;
		int              trials;
		factor_beat_t    b;
		next_factors.delete();
		trials = 0;
		n = 64'(v);
		b.last = 1'b0;
		b.none = 1'b0;
		if (n < 2) begin
			b.factor = '0;
			b.last = 1'b1;
			b.none = 1'b1;
			next_factors.push_back(b);
			return 0;
		end
		while (n[0] == 1'b0) begin
			b.factor = VW'(TWO);
			next_factors.push_back(b);
			n = n >> 1;
		end
		for (d = 64'(THREE); d <= n / d && next_factors.size() < MAX_RESULTS; d += 2) begin
			trials++;
			while (n % d == 0 && next_factors.size() < MAX_RESULTS) begin
				b.factor = d[VW-1:0];
				next_factors.push_back(b);
				n = n / d;
			end
		end
		if (n > 2 && next_factors.size() < MAX_RESULTS) begin
			b.factor = n[VW-1:0];
			next_factors.push_back(b);
		end
		b = next_factors.pop_back();
		b.last = 1'b1;
		next_factors.push_back(b);
		return trials;
	endfunction

	function automatic int pick_gap(input logic calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// offers one value; next_factors moves to the expected store on acceptance
	task automatic send_value(input logic [VW-1:0] v);
		int gap;
		gap = pick_gap(((cycles / 2300) % 4) == 2);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(DATA_W - VW){1'b0}}, v};
		do @(posedge clk); while (!s_tready);
		foreach (next_factors[i])
			pending_factors.push_back(next_factors[i]);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_factors.size() != 0);
	endtask

	// output side: random stalls, calm stretches, one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				rx_beats++;
			if (rx_beats == HOLD_AT && hold_left == 0 && m_tvalid && m_tready)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (((cycles / 1500) % 4) == 1) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left = pick_gap(1'b0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_factors.size() == 0) begin
				$error("beat with nothing expected: factor %0d last %0b no_factors %0b",
					m_tdata[VW-1:0], m_tlast, m_tuser);
				errors++;
			end else begin
				want = pending_factors.pop_front();
				if (m_tdata[VW-1:0] !== want.factor) begin
					$error("factor: expected %0d, got %0d", want.factor, m_tdata[VW-1:0]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
				if (m_tuser !== want.none) begin
					$error("no_factors: expected %0b, got %0b", want.none, m_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		int              r;
		int              misses;
		longint unsigned prod;
		logic [VW-1:0]   v;
		logic            found_cheap;
		factor_beat_t    b;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].typed) begin
				next_factors.delete();
				b.factor = directed[i].factor;
				b.last   = 1'b1;
				b.none   = directed[i].none;
				next_factors.push_back(b);
			end else begin
				void'(factorize(directed[i].value));
			end
			send_value(directed[i].value);
		end
		wait_drained();

		for (int k = 0; k < N_RANDOM; k++) begin
			r = $urandom_range(0, 99);
			found_cheap = 1'b0;
			v = '0;
			if (r < 55) begin
				v = VW'($urandom_range(0, 4095));
				found_cheap = 1'b1;
			end else if (r >= 80) begin
				// full-width values, kept only when they factor within MAX_TRIALS odd trials
				for (int t = 0; t < 20 && !found_cheap; t++) begin
					v = VW'($urandom);
					if (factorize(v) <= MAX_TRIALS)
						found_cheap = 1'b1;
				end
			end
			if (!found_cheap) begin
				// smooth value: product of small primes up to the top bits
				prod = 1;
				misses = 0;
				while (misses < 4) begin
					r = small_primes[4'($urandom_range(0, 15))];
					if (prod * r <= VALUE_MAX)
						prod = prod * r;
					else
						misses++;
					if ($urandom_range(0, 29) == 0)
						misses = 4;
				end
				v = prod[VW-1:0];
			end
			void'(factorize(v));
			send_value(v);
			if (k == N_RANDOM / 2)
				wait_drained();
		end
		s_tvalid <= 1'b0;

		while (pending_factors.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("tb_trial_division_factorizer_top OK");
		else
			$display("tb_trial_division_factorizer_top NOT OK");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_divider.sv
hw/rtl/tdf_emit.sv
hw/rtl/trial_division_factorizer_top.sv
verif/tb_trial_division_factorizer_top.sv
